FILE: rtl/core/svm_pkg.sv
// ----------------------------------------------------------------------------
// svm_pkg
// Shared types, constants and helpers of the 16-bit register machine core.
// ----------------------------------------------------------------------------
package svm_pkg;

    localparam int MEM_BYTES = 65536;
    localparam int MEM_AW    = $clog2(MEM_BYTES);
    localparam int QDEPTH    = 2;
    localparam int QAW       = $clog2(QDEPTH);

    localparam logic [1:0] OPC_WRITE = 2'd0;
    localparam logic [1:0] OPC_RESET = 2'd1;
    localparam logic [1:0] OPC_EXEC  = 2'd2;

    localparam logic [1:0] CFG_START = 2'd0;
    localparam logic [1:0] CFG_BASE  = 2'd1;
    localparam logic [1:0] CFG_END   = 2'd2;

    localparam logic [3:0] OP_BR   = 4'd0;
    localparam logic [3:0] OP_AND  = 4'd1;
    localparam logic [3:0] OP_NOT  = 4'd2;
    localparam logic [3:0] OP_ADD  = 4'd3;
    localparam logic [3:0] OP_LD   = 4'd4;
    localparam logic [3:0] OP_ST   = 4'd5;
    localparam logic [3:0] OP_PRN  = 4'd6;
    localparam logic [3:0] OP_SCAN = 4'd7;
    localparam logic [3:0] OP_PUSH = 4'd8;
    localparam logic [3:0] OP_POP  = 4'd9;
    localparam logic [3:0] OP_CALL = 4'd10;
    localparam logic [3:0] OP_RET  = 4'd11;

    localparam logic [2:0] FLAG_P = 3'b001;
    localparam logic [2:0] FLAG_Z = 3'b010;
    localparam logic [2:0] FLAG_N = 3'b100;
    localparam logic [2:0] SP_REG = 3'd6;
    localparam logic [2:0] BP_REG = 3'd7;

    typedef enum logic [1:0] {K_WR, K_RST, K_EXE, K_NOP} t_kind;

    typedef enum logic [2:0] {
        ST_IDLE, ST_MRD, ST_EXA, ST_EXB, ST_MWR, ST_EMIT
    } t_state;

    typedef struct packed {
        logic [15:0] start_pointer;
        logic [15:0] data_base;
        logic [16:0] memory_end;
    } t_cfg;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] mem_addr;
        logic [7:0]  mem_byte;
        logic [15:0] scan_value;
    } t_item;

    typedef struct packed {
        logic [15:0] next_pointer;
        logic        halted;
        logic        print_valid;
        logic [15:0] print_value;
        logic [2:0]  condition_flags;
    } t_res;

    function automatic logic [2:0] flags_of(input logic [15:0] v);
        logic [2:0] f;
        if (v == 16'd0) f = FLAG_Z;
        else if (v[15]) f = FLAG_N;
        else f = FLAG_P;
        return f;
    endfunction

    function automatic logic [15:0] sext5(input logic [4:0] x);
        return {{11{x[4]}}, x};
    endfunction

    function automatic logic [15:0] sext9(input logic [8:0] x);
        return {{7{x[8]}}, x};
    endfunction

    function automatic logic [15:0] sext11(input logic [10:0] x);
        return {{5{x[10]}}, x};
    endfunction

endpackage

FILE: rtl/core/svm_ifs.sv
// ----------------------------------------------------------------------------
// svm_ifs
// Handshake channels of the core: command words, result words, config writes.
// ----------------------------------------------------------------------------
interface svm_item_if;
    logic               valid;
    logic               ready;
    logic [1:0]         opcode;
    logic [15:0]        mem_addr;
    logic [7:0]         mem_byte;
    logic signed [15:0] scan_value;
    modport source (output valid, opcode, mem_addr, mem_byte, scan_value, input ready);
    modport sink   (input valid, opcode, mem_addr, mem_byte, scan_value, output ready);
endinterface

interface svm_res_if;
    logic               valid;
    logic               ready;
    logic [15:0]        next_pointer;
    logic               halted;
    logic               print_valid;
    logic signed [15:0] print_value;
    logic [2:0]         condition_flags;
    modport source (output valid, next_pointer, halted, print_valid, print_value,
                    condition_flags, input ready);
    modport sink   (input valid, next_pointer, halted, print_valid, print_value,
                    condition_flags, output ready);
endinterface

interface svm_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [16:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/core/stack_vm_cpu_core_unit.sv
// ----------------------------------------------------------------------------
// stack_vm_cpu_core_unit
// 16-bit register machine with a private 64 KiB byte memory.
// ----------------------------------------------------------------------------
// i_item carries command words: write a memory byte, reset the machine, or
// execute one instruction. o_res returns exactly one result word per command.
// i_cfg writes start pointer, data base and memory end; it is always ready. It
// is to be used only while the core is idle; the core does not enforce this.
// Commands queue in a two-word buffer, so the front keeps accepting while the
// back end works or while a result waits on o_res.
// Each word is carried out by the single-port memory sequencer: it is dequeued,
//   then for execute fetched and run in EXA and EXB, followed by memory reads
//   for LD, POP, RET or writes for ST, PUSH, SCAN to memory and CALL.
// Reset clears registers, pointer and the queue and sets the Z flag; memory
// contents are undefined until written. A stalled o_res holds its word, the
// back end waits and the queue fills before i_item.ready drops.
// ----------------------------------------------------------------------------
module stack_vm_cpu_core_unit (
    input  logic     i_clk,
    input  logic     i_rst_n,
    svm_item_if.sink i_item,
    svm_res_if.source o_res,
    svm_cfg_if.sink  i_cfg
);
    import svm_pkg::*;

    t_cfg  r_cfg;
    t_item q_item;
    t_res  res;
    logic  q_valid, q_pop;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_pointer <= '0;
            r_cfg.data_base     <= '0;
            r_cfg.memory_end    <= 17'h10000;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_START: r_cfg.start_pointer <= i_cfg.data[15:0];
                CFG_BASE:  r_cfg.data_base     <= i_cfg.data[15:0];
                CFG_END:   r_cfg.memory_end    <= i_cfg.data;
                default: ;
            endcase
        end
    end

    svm_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    svm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_valid   (q_valid),
        .i_q_item    (q_item),
        .o_pop       (q_pop),
        .o_res_valid (o_res.valid),
        .o_res       (res),
        .i_res_ready (o_res.ready)
    );

    assign o_res.next_pointer    = res.next_pointer;
    assign o_res.halted          = res.halted;
    assign o_res.print_valid     = res.print_valid;
    assign o_res.print_value     = $signed(res.print_value);
    assign o_res.condition_flags = res.condition_flags;
endmodule

FILE: rtl/core/svm_ram.sv
// ----------------------------------------------------------------------------
// svm_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module svm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

FILE: rtl/core/svm_front.sv
// ----------------------------------------------------------------------------
// svm_front
// Accepts command words, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module svm_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    svm_item_if.sink      i_item,
    input  logic          i_pop,
    output logic          o_valid,
    output svm_pkg::t_item o_item
);
    import svm_pkg::*;

    t_item          r_q [QDEPTH];
    logic [QAW-1:0] r_wp, r_rp;
    logic [QAW:0]   r_cnt;
    logic           push, pop;
    t_item          cls;

    assign i_item.ready = (r_cnt != QAW'(0) + (QAW+1)'(QDEPTH));
    assign push    = i_item.valid && i_item.ready;
    assign o_valid = (r_cnt != '0);
    assign pop     = i_pop && o_valid;
    assign o_item  = r_q[r_rp];

    always_comb begin
        case (i_item.opcode)
            OPC_WRITE: cls.kind = K_WR;
            OPC_RESET: cls.kind = K_RST;
            OPC_EXEC:  cls.kind = K_EXE;
            default:   cls.kind = K_NOP;
        endcase
        cls.mem_addr   = i_item.mem_addr;
        cls.mem_byte   = i_item.mem_byte;
        cls.scan_value = i_item.scan_value;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_q[r_wp] <= cls;
                r_wp      <= r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (QAW+1)'(push) - (QAW+1)'(pop);
        end
    end
endmodule

FILE: rtl/core/svm_back.sv
// ----------------------------------------------------------------------------
// svm_back
// Sequencer that carries out queued words against the register file and the
// byte memory, and holds the result word until it is taken.
// ----------------------------------------------------------------------------
module svm_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  svm_pkg::t_cfg  i_cfg,
    input  logic           i_q_valid,
    input  svm_pkg::t_item i_q_item,
    output logic           o_pop,
    output logic           o_res_valid,
    output svm_pkg::t_res  o_res,
    input  logic           i_res_ready
);
    import svm_pkg::*;

    t_state        r_state, n_state;
    logic [15:0]   r_regs [8];
    logic [15:0]   r_ip;
    logic [2:0]    r_flags;
    logic          r_pv;
    logic [15:0]   r_pval;
    logic          r_ov;
    t_res          r_res;
    logic [2:0]    r_k, r_n;
    logic          r_fetch;
    logic [15:0]   r_base, r_w0, r_w1, r_ins, r_a, r_scan;
    logic [31:0]   r_rd;

    logic              ram_we;
    logic [MEM_AW-1:0] ram_addr;
    logic [7:0]        ram_wdata, ram_q;
    logic [15:0]       acc_addr, wsel, alu_v, bval, rf_q, sp, bp, ld_base;
    logic [2:0]        rd_sel;
    logic [31:0]       rd_full;
    logic              slot_free, halted_now;
    logic [3:0]        op;
    logic [2:0]        f9, f6, f8, f0;

    svm_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_q)
    );

    assign op  = r_ins[15:12];
    assign f9  = r_ins[11:9];
    assign f6  = r_ins[8:6];
    assign f8  = r_ins[10:8];
    assign f0  = r_ins[2:0];
    assign sp  = r_regs[SP_REG];
    assign bp  = r_regs[BP_REG];

    assign slot_free   = !r_ov || i_res_ready;
    assign halted_now  = ({1'b0, r_ip} >= i_cfg.memory_end);
    assign acc_addr    = r_base + {13'd0, r_k};
    assign wsel        = r_k[1] ? r_w1 : r_w0;
    assign rd_full     = {r_rd[23:0], ram_q};
    assign rf_q        = r_regs[rd_sel];
    assign bval        = r_ins[5] ? sext5(r_ins[4:0]) : rf_q;
    assign ld_base     = i_cfg.data_base + (r_ins[8] ? r_a : {8'd0, r_ins[7:0]});
    assign o_res_valid = r_ov;
    assign o_res       = r_res;

    always_comb begin
        case (op)
            OP_AND:  alu_v = r_a & bval;
            OP_ADD:  alu_v = r_a + bval;
            default: alu_v = ~r_a;
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    if (i_q_item.kind == K_EXE && !halted_now) n_state = ST_MRD;
                    else n_state = ST_EMIT;
                end
            end
            ST_MRD: begin
                if (r_k == r_n) n_state = r_fetch ? ST_EXA : ST_EMIT;
            end
            ST_EXA: n_state = ST_EXB;
            ST_EXB: begin
                case (op)
                    OP_LD, OP_POP, OP_RET:   n_state = ST_MRD;
                    OP_ST, OP_PUSH, OP_CALL: n_state = ST_MWR;
                    OP_SCAN:                 n_state = r_ins[11] ? ST_EMIT : ST_MWR;
                    default:                 n_state = ST_EMIT;
                endcase
            end
            ST_MWR: begin
                if (r_k == r_n - 3'd1) n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (slot_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_pop     = 1'b0;
        ram_we    = 1'b0;
        ram_addr  = acc_addr[MEM_AW-1:0];
        ram_wdata = r_k[0] ? wsel[7:0] : wsel[15:8];
        rd_sel    = f0;
        case (r_state)
            ST_IDLE: begin
                o_pop = i_q_valid;
                if (i_q_valid && i_q_item.kind == K_WR) begin
                    ram_we    = 1'b1;
                    ram_addr  = i_q_item.mem_addr[MEM_AW-1:0];
                    ram_wdata = i_q_item.mem_byte;
                end
            end
            ST_EXA: begin
                case (op)
                    OP_AND, OP_ADD, OP_NOT: rd_sel = f6;
                    OP_LD, OP_ST:           rd_sel = f0;
                    default:                rd_sel = f8;
                endcase
            end
            ST_EXB: rd_sel = (op == OP_ST) ? f9 : f0;
            ST_MWR: ram_we = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ip    <= '0;
            r_flags <= FLAG_Z;
            r_ov    <= 1'b0;
            r_pv    <= 1'b0;
            r_fetch <= 1'b0;
            r_k     <= '0;
            r_n     <= '0;
            for (int i = 0; i < 8; i++) r_regs[i] <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_EMIT && slot_free) begin
                r_ov  <= 1'b1;
                r_res <= '{next_pointer: r_ip, halted: halted_now, print_valid: r_pv,
                           print_value: r_pval, condition_flags: r_flags};
            end else if (i_res_ready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_q_valid) begin
                        r_scan <= i_q_item.scan_value;
                        r_pv   <= 1'b0;
                        r_pval <= '0;
                        case (i_q_item.kind)
                            K_RST: begin
                                for (int i = 0; i < 8; i++) r_regs[i] <= '0;
                                r_ip    <= i_cfg.start_pointer;
                                r_flags <= FLAG_Z;
                            end
                            K_EXE: begin
                                r_base  <= r_ip;
                                r_n     <= 3'd2;
                                r_k     <= '0;
                                r_fetch <= 1'b1;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_MRD: begin
                    r_k  <= r_k + 3'd1;
                    r_rd <= rd_full;
                    if (r_k == r_n) begin
                        if (r_fetch) begin
                            r_ins   <= rd_full[15:0];
                            r_fetch <= 1'b0;
                        end else begin
                            case (op)
                                OP_LD: begin
                                    r_regs[f9] <= rd_full[15:0];
                                    r_flags    <= flags_of(rd_full[15:0]);
                                end
                                OP_POP: begin
                                    r_regs[f0]     <= rd_full[15:0];
                                    r_regs[SP_REG] <= ((f0 == SP_REG) ? rd_full[15:0] : sp)
                                                      - 16'd2;
                                end
                                OP_RET: begin
                                    r_ip           <= rd_full[15:0] + 16'd2;
                                    r_regs[BP_REG] <= rd_full[31:16];
                                    r_regs[SP_REG] <= sp - 16'd4;
                                end
                                default: ;
                            endcase
                        end
                    end
                end
                ST_EXA: r_a <= rf_q;
                ST_EXB: begin
                    r_k  <= '0;
                    r_ip <= r_ip + 16'd2;
                    case (op)
                        OP_BR: begin
                            if ((f9 & r_flags) != 3'd0)
                                r_ip <= r_ip + 16'd2 + sext9(r_ins[8:0]);
                        end
                        OP_AND, OP_ADD, OP_NOT: begin
                            r_regs[f9] <= alu_v;
                            r_flags    <= flags_of(alu_v);
                        end
                        OP_LD: begin
                            r_base <= ld_base;
                            r_n    <= 3'd2;
                        end
                        OP_ST: begin
                            r_base  <= ld_base;
                            r_w0    <= rf_q;
                            r_flags <= flags_of(rf_q);
                            r_n     <= 3'd2;
                        end
                        OP_PRN: begin
                            if (r_ins[11]) begin
                                r_pv   <= 1'b1;
                                r_pval <= r_a;
                            end
                        end
                        OP_SCAN: begin
                            if (r_ins[11]) begin
                                r_regs[f8] <= r_scan;
                            end else begin
                                r_base <= i_cfg.data_base + {5'd0, r_ins[10:0]};
                                r_w0   <= r_scan;
                                r_n    <= 3'd2;
                            end
                        end
                        OP_PUSH: begin
                            r_w0           <= r_ins[11] ? r_a : sext11(r_ins[10:0]);
                            r_base         <= sp + 16'd1;
                            r_regs[SP_REG] <= sp + 16'd2;
                            r_n            <= 3'd2;
                        end
                        OP_POP: begin
                            r_base <= sp - 16'd1;
                            r_n    <= 3'd2;
                        end
                        OP_CALL: begin
                            r_w0           <= bp;
                            r_w1           <= r_ip;
                            r_base         <= sp + 16'd1;
                            r_regs[SP_REG] <= sp + 16'd4;
                            r_regs[BP_REG] <= sp + 16'd4;
                            r_n            <= 3'd4;
                            r_ip           <= r_ip + 16'd2 + sext9(r_ins[8:0]);
                        end
                        OP_RET: begin
                            r_base <= sp - 16'd3;
                            r_n    <= 3'd4;
                        end
                        default: ;
                    endcase
                end
                ST_MWR: r_k <= r_k + 3'd1;
                default: ;
            endcase
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MRD || r_state == ST_MWR) |-> (r_k <= r_n))
        else $error("memory step counter overran");

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (r_state == ST_IDLE))
        else $error("queue popped outside idle");

    a_emit_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT && !slot_free) |=> (r_state == ST_EMIT && r_ov))
        else $error("result lost while output full");

    a_write_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == ST_IDLE || r_state == ST_MWR))
        else $error("unexpected memory write");
endmodule

FILE: sim/stack_vm_cpu_core_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stack_vm_cpu_core_unit_tb
// Self-checking bench for the 16-bit register machine core. A directed
// program exercises ADD, print, both scan forms, LD, ST, PUSH, CALL, POP and
// RET. Random phases then load and run programs under several pointer, base
// and end settings. Every result word is checked against an in-bench machine
// model or a fixed word. Loads keep unwritten bytes from being fetched or read.
// ----------------------------------------------------------------------------
module stack_vm_cpu_core_unit_tb;
    import svm_pkg::*;

    localparam logic [1:0] OPC_SPARE = 2'd3;
    localparam int         IDLE_LIMIT = 2000;

    typedef struct {
        logic [1:0]  opc;
        logic [15:0] scan;
        bit          chk;
        t_res        want;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    svm_item_if item_if();
    svm_res_if  res_if();
    svm_cfg_if  cfg_if();

    stack_vm_cpu_core_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_if),
        .o_res   (res_if),
        .i_cfg   (cfg_if)
    );

    always #5 i_clk = ~i_clk;

    // machine model state
    logic [15:0] gpr [8];
    logic [15:0] ip;
    logic [2:0]  cc;
    logic [7:0]  mem [0:65535];
    bit          known [0:65535];
    logic [15:0] cfg_start;
    logic [15:0] cfg_base;
    logic [16:0] cfg_end;

    t_res pending [$];
    int   errors = 0;
    int   n_exec = 0;
    int   n_print = 0;
    int   n_halt = 0;
    int   idle_cnt = 0;
    bit   calm = 1'b0;

    task automatic report(string what, int got, int want);
        $display("mismatch %s: got %0h want %0h", what, got, want);
        errors++;
    endtask

    function automatic logic [15:0] rd16(logic [15:0] a);
        logic [15:0] b;
        b = a + 16'd1;
        return {mem[a], mem[b]};
    endfunction

    function automatic void wr16(logic [15:0] a, logic [15:0] v);
        logic [15:0] b;
        b = a + 16'd1;
        mem[a] = v[15:8];
        mem[b] = v[7:0];
        known[a] = 1'b1;
        known[b] = 1'b1;
    endfunction

    function automatic void set_cc(logic [15:0] v);
        if (v == 16'd0) cc = FLAG_Z;
        else if (v[15]) cc = FLAG_N;
        else cc = FLAG_P;
    endfunction

    function automatic void stack_push(logic [15:0] v);
        gpr[SP_REG] = gpr[SP_REG] + 16'd2;
        wr16(gpr[SP_REG] - 16'd1, v);
    endfunction

    function automatic t_res machine_step(logic [1:0] opc, logic [15:0] addr,
                                          logic [7:0] b, logic [15:0] scan);
        t_res        r;
        logic [15:0] ins;
        logic [15:0] v;
        logic [15:0] a;
        logic [2:0]  d;
        logic [2:0]  s1;
        logic [2:0]  s8;
        logic [2:0]  s0;
        r = '0;
        case (opc)
            OPC_WRITE: begin
                mem[addr] = b;
                known[addr] = 1'b1;
            end
            OPC_RESET: begin
                foreach (gpr[i]) gpr[i] = 16'd0;
                ip = cfg_start;
                cc = FLAG_Z;
            end
            OPC_EXEC: if ({1'b0, ip} < cfg_end) begin
                ins = rd16(ip);
                d  = ins[11:9];
                s1 = ins[8:6];
                s8 = ins[10:8];
                s0 = ins[2:0];
                n_exec++;
                case (ins[15:12])
                    OP_BR: if ((d & cc) != 3'd0) ip = ip + {{7{ins[8]}}, ins[8:0]};
                    OP_AND, OP_ADD: begin
                        v = ins[5] ? {{11{ins[4]}}, ins[4:0]} : gpr[s0];
                        v = (ins[15:12] == OP_AND) ? (gpr[s1] & v) : (gpr[s1] + v);
                        gpr[d] = v;
                        set_cc(v);
                    end
                    OP_NOT: begin
                        v = ~gpr[s1];
                        gpr[d] = v;
                        set_cc(v);
                    end
                    OP_LD, OP_ST: begin
                        a = cfg_base + (ins[8] ? gpr[s0] : {8'd0, ins[7:0]});
                        if (ins[15:12] == OP_LD) begin
                            v = rd16(a);
                            gpr[d] = v;
                        end else begin
                            v = gpr[d];
                            wr16(a, v);
                        end
                        set_cc(v);
                    end
                    OP_PRN: if (ins[11]) begin
                        r.print_valid = 1'b1;
                        r.print_value = gpr[s8];
                        n_print++;
                    end
                    OP_SCAN: begin
                        if (ins[11]) gpr[s8] = scan;
                        else wr16(cfg_base + {5'd0, ins[10:0]}, scan);
                    end
                    OP_PUSH: stack_push(ins[11] ? gpr[s8] : {{5{ins[10]}}, ins[10:0]});
                    OP_POP: begin
                        v = rd16(gpr[SP_REG] - 16'd1);
                        gpr[s0] = v;
                        gpr[SP_REG] = gpr[SP_REG] - 16'd2;
                    end
                    OP_CALL: begin
                        stack_push(gpr[BP_REG]);
                        stack_push(ip);
                        gpr[BP_REG] = gpr[SP_REG];
                        ip = ip + {{7{ins[8]}}, ins[8:0]};
                    end
                    OP_RET: begin
                        ip = rd16(gpr[SP_REG] - 16'd1);
                        gpr[SP_REG] = gpr[SP_REG] - 16'd2;
                        gpr[BP_REG] = rd16(gpr[SP_REG] - 16'd1);
                        gpr[SP_REG] = gpr[SP_REG] - 16'd2;
                    end
                    default: ;
                endcase
                ip = ip + 16'd2;
            end
            default: ;
        endcase
        r.next_pointer = ip;
        r.halted = ({1'b0, ip} >= cfg_end);
        r.condition_flags = cc;
        if (r.halted) n_halt++;
        return r;
    endfunction

    task automatic issue(logic [1:0] opc, logic [15:0] addr, logic [7:0] b,
                         logic [15:0] scan, bit chk, t_res want);
        t_res r;
        int   gap;
        r = machine_step(opc, addr, b, scan);
        pending.push_back(chk ? want : r);
        gap = calm ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            item_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        item_if.valid      <= 1'b1;
        item_if.opcode     <= opc;
        item_if.mem_addr   <= addr;
        item_if.mem_byte   <= b;
        item_if.scan_value <= scan;
        @(posedge i_clk);
        while (!item_if.ready) @(posedge i_clk);
    endtask

    task automatic put(logic [1:0] opc, logic [15:0] addr, logic [7:0] b);
        issue(opc, addr, b, 16'($urandom), 1'b0, '0);
    endtask

    task automatic drain();
        item_if.valid <= 1'b0;
        while (pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [1:0] idx, logic [16:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        cfg_if.valid <= 1'b0;
        @(posedge i_clk);
        case (idx)
            CFG_START: cfg_start = val[15:0];
            CFG_BASE:  cfg_base  = val[15:0];
            CFG_END:   cfg_end   = val;
            default: ;
        endcase
    endtask

    // load a fresh instruction when needed or at random, then every unwritten byte the step will read
    task automatic run_step();
        logic [15:0] ins;
        logic [15:0] sp;
        logic [15:0] rd [$];
        logic [15:0] a;
        if ({1'b0, ip} < cfg_end) begin
            a = ip + 16'd1;
            if (!known[ip] || !known[a] || $urandom_range(0, 9) < 3) begin
                ins = {4'($urandom_range(0, 15)), 12'($urandom)};
                put(OPC_WRITE, ip, ins[15:8]);
                put(OPC_WRITE, a, ins[7:0]);
            end
            ins = rd16(ip);
            sp = gpr[SP_REG];
            case (ins[15:12])
                OP_LD: begin
                    a = cfg_base + (ins[8] ? gpr[ins[2:0]] : {8'd0, ins[7:0]});
                    rd = '{a, a + 16'd1};
                end
                OP_POP: rd = '{sp - 16'd1, sp};
                OP_RET: rd = '{sp - 16'd1, sp, sp - 16'd3, sp - 16'd2};
                default: ;
            endcase
            foreach (rd[i]) if (!known[rd[i]]) put(OPC_WRITE, rd[i], 8'($urandom));
        end
        put(OPC_EXEC, 16'($urandom), 8'($urandom));
    endtask

    // result side
    initial begin : result_side
        int   stall;
        t_res want;
        res_if.ready <= 1'b0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            stall = calm ? 0 : $urandom_range(0, 19);
            if (stall > 0) begin
                res_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_if.ready <= 1'b1;
            @(posedge i_clk);
            while (!res_if.valid) @(posedge i_clk);
            if (pending.size() == 0) begin
                report("unexpected word", res_if.next_pointer, 0);
            end else begin
                want = pending.pop_front();
                if (res_if.next_pointer !== want.next_pointer)
                    report("next_pointer", res_if.next_pointer, want.next_pointer);
                if (res_if.halted !== want.halted)
                    report("halted", res_if.halted, want.halted);
                if (res_if.print_valid !== want.print_valid)
                    report("print_valid", res_if.print_valid, want.print_valid);
                if (res_if.print_value !== want.print_value)
                    report("print_value", res_if.print_value, want.print_value);
                if (res_if.condition_flags !== want.condition_flags)
                    report("condition_flags", res_if.condition_flags,
                           want.condition_flags);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((item_if.valid && item_if.ready) || (res_if.valid && res_if.ready) ||
                (cfg_if.valid && cfg_if.ready)) begin
                idle_cnt <= 0;
            end else if (idle_cnt >= IDLE_LIMIT) begin
                $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
                $display("** stack_vm_cpu_core_unit: FAILED **");
                $finish;
            end else begin
                idle_cnt <= idle_cnt + 1;
            end
        end
    end

    initial begin : stimulus
        logic [15:0] prog [12];
        logic [15:0] phase_start [4];
        logic [15:0] phase_base [4];
        logic [16:0] phase_end [4];
        int          phase_len [4];
        t_row        rows [12];
        t_res        after_rst;
        int          r;

        item_if.valid <= 1'b0;
        item_if.opcode <= OPC_WRITE;
        item_if.mem_addr <= '0;
        item_if.mem_byte <= '0;
        item_if.scan_value <= '0;
        cfg_if.valid <= 1'b0;
        cfg_if.index <= CFG_START;
        cfg_if.data <= '0;

        foreach (gpr[i]) gpr[i] = 16'd0;
        foreach (known[i]) known[i] = 1'b0;
        ip = 16'd0;
        cc = FLAG_Z;
        cfg_start = 16'd0;
        cfg_base = 16'd0;
        cfg_end = 17'h10000;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ADD, PRINT, SCAN reg, SCAN mem, LD, ST, PUSH, CALL, POP, RET, BR, unused opcode
        prog = '{16'h3230, 16'h6900, 16'h7B00, 16'h77FF, 16'h4B03, 16'h52FF,
                 16'h8400, 16'hA002, 16'h9004, 16'hB000, 16'h0E00, 16'hF000};
        after_rst = '{16'd0, 1'b0, 1'b0, 16'd0, FLAG_Z};
        rows = '{
            '{OPC_RESET, 16'h0000, 1'b1, after_rst},
            '{OPC_SPARE, 16'hFFFF, 1'b1, after_rst},
            '{OPC_EXEC,  16'h0000, 1'b0, '0},
            '{OPC_EXEC,  16'h0000, 1'b1, '{16'd4, 1'b0, 1'b1, 16'hFFF0, FLAG_N}},
            '{OPC_EXEC,  16'h07FF, 1'b0, '0},
            '{OPC_EXEC,  16'h8001, 1'b0, '0},
            '{OPC_EXEC,  16'h7FFF, 1'b0, '0},
            '{OPC_EXEC,  16'h8000, 1'b0, '0},
            '{OPC_EXEC,  16'h0001, 1'b0, '0},
            '{OPC_EXEC,  16'h0000, 1'b0, '0},
            '{OPC_EXEC,  16'h0000, 1'b0, '0},
            '{OPC_EXEC,  16'h0000, 1'b0, '0}
        };

        put(OPC_WRITE, 16'hFFFF, 8'hFF);
        foreach (prog[i]) begin
            put(OPC_WRITE, 16'(2 * i), prog[i][15:8]);
            put(OPC_WRITE, 16'(2 * i + 1), prog[i][7:0]);
        end
        foreach (rows[i])
            issue(rows[i].opc, 16'($urandom), 8'($urandom), rows[i].scan,
                  rows[i].chk, rows[i].want);
        drain();

        phase_start = '{16'h0100, 16'hFFF0, 16'h4000, 16'h0000};
        phase_base  = '{16'hFFFF, 16'h0000, 16'h8000, 16'h1234};
        phase_end   = '{17'h10000, 17'h0FFF8, 17'h00000, 17'h00200};
        phase_len   = '{70, 50, 30, 70};

        for (int p = 0; p < 4; p++) begin
            calm = (p == 1);
            cfg_write(CFG_START, {1'b0, phase_start[p]});
            cfg_write(CFG_BASE, {1'b0, phase_base[p]});
            cfg_write(CFG_END, phase_end[p]);
            put(OPC_RESET, 16'($urandom), 8'($urandom));
            for (int k = 0; k < phase_len[p]; k++) begin
                if (p == 0 && k == 35) drain();
                r = $urandom_range(0, 99);
                if (r < 70) run_step();
                else if (r < 82) put(OPC_WRITE, 16'($urandom), 8'($urandom));
                else if (r < 90) put(OPC_SPARE, 16'($urandom), 8'($urandom));
                else put(OPC_RESET, 16'($urandom), 8'($urandom));
            end
            drain();
        end
        calm = 1'b0;

        $display("covered %0d executed instructions, %0d prints, %0d halted words",
                 n_exec, n_print, n_halt);
        $display("four register settings, including an always-halted end and a wrapping pointer");
        if (errors == 0) begin
            $display("** stack_vm_cpu_core_unit: PASSED **");
        end else begin
            $display("** stack_vm_cpu_core_unit: FAILED **");
        end
        $finish;
    end

endmodule
